// ----- rtl/core/wildcard_glob_match_macros.svh -----
// Assertion helpers for the checker file.
`ifndef WILDCARD_GLOB_MATCH_MACROS_SVH
`define WILDCARD_GLOB_MATCH_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define WGM_AST_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wgm check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define WGM_AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wgm check failed");

`endif

// ----- rtl/core/wgm_pkg.sv -----
package wgm_pkg;

	// default mask capacity
	localparam int MASK_MAX_DEF = 32;

	// wildcard characters
	localparam logic [7:0] STAR_CH  = 8'h2A;
	localparam logic [7:0] QMARK_CH = 8'h3F;

	// command codes carried in tuser
	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_NAME   = 2'd2,
		CMD_END    = 2'd3
	} cmd_t;

	// mask store controls
	typedef struct packed {
		logic clear;
		logic append;
	} mask_ctrl_t;

	// position set controls
	typedef struct packed {
		logic restart;
		logic step;
	} nfa_ctrl_t;

endpackage

// ----- rtl/core/wgm_mask.sv -----
// Mask character store with per-position star and literal-hit vectors.
module wgm_mask
	import wgm_pkg::*;
#(
	parameter int MASK_MAX = MASK_MAX_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mask_ctrl_t                       ctrl,
	input  logic [7:0]                       sym,
	output logic [MASK_MAX:0]                star_vec,
	output logic [MASK_MAX:0]                lit_vec,
	output logic [$clog2(MASK_MAX+1)-1:0]    count,
	output logic                             overflow
);

	localparam int CNT_W  = $clog2(MASK_MAX + 1);
	localparam int ADDR_W = (MASK_MAX > 1) ? $clog2(MASK_MAX) : 1;

	logic [7:0]       char_q [MASK_MAX];
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             full;

	assign full     = (count_q == CNT_W'(MASK_MAX));
	assign count    = count_q;
	assign overflow = ovf_q;

	// fill count and sticky overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (ctrl.clear) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (ctrl.append) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// character write at the fill position
	always_ff @(posedge clk) begin
		if (ctrl.append && !full) begin
			char_q[count_q[ADDR_W-1:0]] <= sym;
		end
	end

	// per-position decode; positions at or past the count never hit
	always_comb begin
		star_vec = '0;
		lit_vec  = '0;
		for (int p = 0; p < MASK_MAX; p++) begin
			if (CNT_W'(p) < count_q) begin
				star_vec[p] = (char_q[p] == STAR_CH);
				lit_vec[p]  = (char_q[p] != STAR_CH) &&
				              ((char_q[p] == QMARK_CH) || (char_q[p] == sym));
			end
		end
	end

endmodule

// ----- rtl/core/wgm_nfa.sv -----
// Active position set with star closure and one-character step.
module wgm_nfa
	import wgm_pkg::*;
#(
	parameter int MASK_MAX = MASK_MAX_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  nfa_ctrl_t                        ctrl,
	input  logic [MASK_MAX:0]                star_vec,
	input  logic [MASK_MAX:0]                lit_vec,
	input  logic [$clog2(MASK_MAX+1)-1:0]    count,
	output logic                             hit
);

	localparam int POS_W = MASK_MAX + 1;

	logic [POS_W-1:0] active_q;
	logic [POS_W-1:0] gen;
	logic [POS_W-1:0] carry;
	logic [POS_W-1:0] closed;
	logic [POS_W-1:0] lit_hit;
	logic [POS_W-1:0] nxt;

	// star closure as a carry chain: stars propagate, active stars generate
	assign gen     = star_vec & active_q;
	assign carry   = (star_vec + gen) ^ star_vec ^ gen;
	assign closed  = active_q | carry;

	// stars keep their position, literal hits move one up
	assign lit_hit = closed & lit_vec;
	assign nxt     = (closed & star_vec) | {lit_hit[POS_W-2:0], 1'b0};

	assign hit     = closed[count];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= POS_W'(1);
		end else if (ctrl.restart) begin
			active_q <= POS_W'(1);
		end else if (ctrl.step) begin
			active_q <= nxt;
		end
	end

endmodule

// ----- rtl/core/wildcard_glob_match.sv -----
// Channel  Dir  tdata                 tuser
// s_*      in   [7:0] symbol          [1:0] command
// m_*      out  [0] matched, 0 pad    [0] mask_overflow
//
// One word per cycle on s_* while no end-of-name word is stalled; a result word
// is valid once its end-of-name word has passed the input and result registers.
// The star closure is one carry chain across the position vector.
// An end-of-name word waits in the input register only while the result
// register is full and m_tready is low; other commands pass regardless.
// Reset (arst_n low) empties both registers, the mask and the overflow flag.
module wildcard_glob_match
	import wgm_pkg::*;
#(
	parameter int MASK_MAX = MASK_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] symbol
	input  logic [1:0] s_tuser,   // [1:0] command
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [0] matched, [7:1] zero
	output logic       m_tuser    // [0] mask_overflow
);

	localparam int CNT_W = $clog2(MASK_MAX + 1);

	logic             valid_s1;
	cmd_t             cmd_s1;
	logic [7:0]       sym_s1;
	logic             out_valid_q;
	logic             matched_q;
	logic             ovf_out_q;
	logic             advance;
	logic             is_end;
	mask_ctrl_t       mask_ctrl;
	nfa_ctrl_t        nfa_ctrl;
	logic [MASK_MAX:0] star_vec;
	logic [MASK_MAX:0] lit_vec;
	logic [CNT_W-1:0] count;
	logic             overflow;
	logic             hit;

	// handshake: end-of-name needs room in the result register
	assign is_end   = (cmd_s1 == CMD_END);
	assign advance  = valid_s1 && (!is_end || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= cmd_t'(s_tuser);
			sym_s1 <= s_tdata;
		end
	end

	// command decode
	always_comb begin
		mask_ctrl = '0;
		nfa_ctrl  = '0;
		unique case (cmd_s1)
			CMD_CLEAR: begin
				mask_ctrl.clear  = advance;
				nfa_ctrl.restart = advance;
			end
			CMD_APPEND: begin
				mask_ctrl.append = advance;
			end
			CMD_NAME: begin
				nfa_ctrl.step = advance;
			end
			CMD_END: begin
				nfa_ctrl.restart = advance;
			end
			default: begin
				mask_ctrl = '0;
				nfa_ctrl  = '0;
			end
		endcase
	end

	wgm_mask #(
		.MASK_MAX (MASK_MAX)
	) u_mask (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (mask_ctrl),
		.sym      (sym_s1),
		.star_vec (star_vec),
		.lit_vec  (lit_vec),
		.count    (count),
		.overflow (overflow)
	);

	wgm_nfa #(
		.MASK_MAX (MASK_MAX)
	) u_nfa (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (nfa_ctrl),
		.star_vec (star_vec),
		.lit_vec  (lit_vec),
		.count    (count),
		.hit      (hit)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_end) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_end) begin
			matched_q <= hit && !overflow;
			ovf_out_q <= overflow;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, matched_q};
	assign m_tuser  = ovf_out_q;

endmodule

// ----- rtl/core/wgm_checker.sv -----
`include "wildcard_glob_match_macros.svh"

// Port-level checks on the result channel.
module wgm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser
);

	// an overflowed mask never reports a match
	`WGM_AST_IMPLY(a_ovf_no_match, m_tvalid && m_tuser, !m_tdata[0])

	// padding bits of the result word stay zero
	`WGM_AST_IMPLY(a_pad_zero, m_tvalid, m_tdata[7:1] == 7'd0)

	// input stalls only behind a stalled result
	`WGM_AST_IMPLY(a_stall_src, !s_tready, m_tvalid && !m_tready)

	// a stalled result holds
	`WGM_AST_NEXT(a_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind wildcard_glob_match wgm_checker u_wgm_checker (.*);

// ----- tb/tb_top.sv -----
module tb_top;
	import wgm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = MASK_MAX_DEF;

	// one end-of-name result
	typedef struct packed {
		logic matched;
		logic overflow;
	} glob_res_t;

	// directed script line; fixed rows carry a hand-derived answer
	typedef struct {
		cmd_t       cmd;
		logic [7:0] sym;
		int         reps;
		bit         fixed;
		bit         want_match;
		bit         want_ovf;
	} script_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;   // [7:0] symbol
	logic [1:0] s_tuser = CMD_CLEAR;   // [1:0] command
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // [0] matched, [7:1] zero
	logic       m_tuser;           // [0] mask_overflow

	// matcher model state
	logic [7:0]   mask_bytes [CAP];
	int           mask_len;
	logic [CAP:0] live;
	bit           ovf_seen;

	glob_res_t pending_res[$];
	int        fault_cnt = 0;
	int        words_sent = 0;
	int        tx_idle_pct = 0;
	int        rx_idle_pct = 0;
	int        rx_hold = 0;

	script_row_t script [26] = '{
		'{CMD_END,    8'h00, 1,  1, 1, 0},  // empty mask, empty name
		'{CMD_NAME,   8'h61, 1,  0, 0, 0},
		'{CMD_END,    8'hFF, 1,  1, 0, 0},  // empty mask, one byte
		'{CMD_APPEND, STAR_CH, 1, 0, 0, 0},
		'{CMD_END,    8'h00, 1,  0, 0, 0},  // star vs empty name
		'{CMD_NAME,   8'hFF, 1,  0, 0, 0},
		'{CMD_NAME,   8'h00, 1,  0, 0, 0},
		'{CMD_END,    8'h00, 1,  0, 0, 0},
		'{CMD_CLEAR,  8'hFF, 1,  0, 0, 0},
		'{CMD_APPEND, QMARK_CH, 1, 0, 0, 0},
		'{CMD_APPEND, 8'hFF, 1,  0, 0, 0},
		'{CMD_NAME,   8'h00, 1,  0, 0, 0},
		'{CMD_NAME,   8'hFF, 1,  0, 0, 0},
		'{CMD_END,    8'h00, 1,  0, 0, 0},
		'{CMD_NAME,   8'h41, 1,  0, 0, 0},
		'{CMD_APPEND, STAR_CH, 1, 0, 0, 0},  // mask grows mid-name
		'{CMD_NAME,   8'h42, 1,  0, 0, 0},
		'{CMD_END,    8'h00, 1,  0, 0, 0},
		'{CMD_CLEAR,  8'h00, 1,  0, 0, 0},
		'{CMD_APPEND, STAR_CH, CAP - 1, 0, 0, 0},  // long star chain, mask full after the next byte
		'{CMD_APPEND, 8'h61, 1,  0, 0, 0},
		'{CMD_NAME,   8'h61, 1,  0, 0, 0},
		'{CMD_END,    8'h00, 1,  0, 0, 0},
		'{CMD_APPEND, 8'h55, 1,  0, 0, 0},  // dropped byte
		'{CMD_END,    8'h00, 1,  1, 0, 1},
		'{CMD_CLEAR,  8'hAA, 1,  0, 0, 0}
	};

	wildcard_glob_match DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	// run limit
	initial begin
		#1_600_000;
		$display("tb_top: errors");
		$finish;
	end

	// carry live positions past every star that can match nothing
	function automatic void close_stars();
		for (int p = 0; p < mask_len; p++) begin
			if (live[p] && mask_bytes[p] == STAR_CH)
				live[p + 1] = 1'b1;
		end
	endfunction

	function automatic void restart_live();
		live = '0;
		live[0] = 1'b1;
	endfunction

	// advance the matcher by one word; emits is set on end of name
	function automatic void match_step(input cmd_t c, input logic [7:0] s,
			output bit emits, output glob_res_t r);
		logic [CAP:0] nxt;
		emits = 0;
		r = '0;
		case (c)
			CMD_CLEAR: begin
				mask_len = 0;
				ovf_seen = 0;
				restart_live();
			end
			CMD_APPEND: begin
				if (mask_len < CAP) begin
					mask_bytes[mask_len] = s;
					mask_len++;
				end else begin
					ovf_seen = 1;
				end
			end
			CMD_NAME: begin
				close_stars();
				nxt = '0;
				for (int p = 0; p < mask_len; p++) begin
					if (live[p]) begin
						if (mask_bytes[p] == STAR_CH)
							nxt[p] = 1'b1;
						else if (mask_bytes[p] == QMARK_CH || mask_bytes[p] == s)
							nxt[p + 1] = 1'b1;
					end
				end
				live = nxt;
			end
			default: begin
				close_stars();
				r.matched = live[mask_len] && !ovf_seen;
				r.overflow = ovf_seen;
				emits = 1;
				restart_live();
			end
		endcase
	endfunction

	// offer one word from a falling edge, return at the falling edge after it is taken
	task automatic send_word(input cmd_t c, input logic [7:0] s, input bit fixed = 0,
			input bit w_match = 0, input bit w_ovf = 0);
		bit        emits;
		glob_res_t r;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'($urandom_range(255));
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= s;
		s_tuser <= c;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		match_step(c, s, emits, r);
		if (emits) begin
			if (fixed) begin
				r.matched = w_match;
				r.overflow = w_ovf;
			end
			pending_res.push_back(r);
		end
		words_sent++;
		@(negedge clk);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_res.size() != 0);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] text_byte();
		if ($urandom_range(99) < 85)
			return 8'($urandom_range(8'h61, 8'h63));
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] mask_byte();
		int roll;
		roll = $urandom_range(99);
		if (roll < 25)
			return STAR_CH;
		if (roll < 45)
			return QMARK_CH;
		return text_byte();
	endfunction

	// clear, load a mask, then test a few names against it; sometimes plain noise
	task automatic run_sequence();
		logic [7:0] mask_q[$];
		logic [7:0] name_q[$];
		int         roll;
		int         len;
		roll = $urandom_range(99);
		if (roll < 10) begin
			repeat ($urandom_range(1, 6))
				send_word(cmd_t'($urandom_range(3)), 8'($urandom_range(255)));
			return;
		end
		roll = $urandom_range(99);
		if (roll < 80)
			len = $urandom_range(0, 8);
		else if (roll < 95)
			len = $urandom_range(9, CAP);
		else
			len = $urandom_range(CAP + 1, CAP + 3);
		send_word(CMD_CLEAR, 8'($urandom_range(255)));
		repeat (len) begin
			mask_q.push_back(mask_byte());
			send_word(CMD_APPEND, mask_q[$]);
		end
		repeat ($urandom_range(1, 4)) begin
			name_q.delete();
			if ($urandom_range(99) < 65) begin
				// name shaped after the mask
				foreach (mask_q[i]) begin
					if (mask_q[i] == STAR_CH)
						repeat ($urandom_range(0, 3)) name_q.push_back(text_byte());
					else if (mask_q[i] == QMARK_CH)
						name_q.push_back(8'($urandom_range(255)));
					else
						name_q.push_back(mask_q[i]);
				end
				if (name_q.size() > 0 && $urandom_range(99) < 25)
					name_q[$urandom_range(name_q.size() - 1)] = text_byte();
			end else begin
				repeat ($urandom_range(0, 10)) name_q.push_back(text_byte());
			end
			foreach (name_q[i]) begin
				if ($urandom_range(99) < 3)
					send_word(CMD_APPEND, mask_byte());
				send_word(CMD_NAME, name_q[i]);
			end
			send_word(CMD_END, 8'($urandom_range(255)));
		end
	endtask

	// receiver ready: random idling, or a counted hold-off
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// compare each taken result word with the oldest prediction
	always @(posedge clk) begin
		glob_res_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_res.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual tdata %h tuser %b",
					$time, m_tdata, m_tuser);
				fault_cnt++;
			end else begin
				exp_r = pending_res.pop_front();
				if (m_tdata[0] !== exp_r.matched) begin
					$display("%0t: matched expected %b actual %b", $time,
						exp_r.matched, m_tdata[0]);
					fault_cnt++;
				end
				if (m_tdata[7:1] !== 7'd0) begin
					$display("%0t: tdata pad expected 0 actual %h", $time, m_tdata[7:1]);
					fault_cnt++;
				end
				if (m_tuser !== exp_r.overflow) begin
					$display("%0t: mask_overflow expected %b actual %b", $time,
						exp_r.overflow, m_tuser);
					fault_cnt++;
				end
			end
		end
	end

	initial begin
		mask_len = 0;
		ovf_seen = 0;
		restart_live();
		foreach (mask_bytes[i])
			mask_bytes[i] = 8'h00;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed script
		tx_idle_pct = 26;
		rx_idle_pct = 68;
		foreach (script[i])
			repeat (script[i].reps)
				send_word(script[i].cmd, script[i].sym, script[i].fixed,
					script[i].want_match, script[i].want_ovf);
		drain();

		// random traffic in three idling phases
		for (int ph = 0; ph < 3; ph++) begin
			tx_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 68 : 0;
			rx_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 26 : 0;
			if (ph == 2) begin
				// receiver held off while end-of-name words keep coming
				rx_hold = 200;
				send_word(CMD_CLEAR, 8'h00);
				send_word(CMD_APPEND, 8'h61);
				send_word(CMD_APPEND, STAR_CH);
				repeat (12) begin
					send_word(CMD_NAME, 8'h61);
					send_word(CMD_END, 8'h00);
				end
				drain();
			end
			while (words_sent < 80 + 240 * (ph + 1))
				run_sequence();
			drain();
		end

		repeat (8) @(posedge clk);
		if (fault_cnt == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
